/* design/tcw_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcw_pkg: shared types and constants of the text console writer
// Holds the datapath operation codes, the controller/datapath command and
// status structs, request mode codes and character constants.
// ----------------------------------------------------------------------------
package tcw_pkg;

   // request modes
   localparam logic [1:0] MODE_PRINT = 2'd0;
   localparam logic [1:0] MODE_CLEAR = 2'd1;
   localparam logic [1:0] MODE_READ  = 2'd2;

   // character and cell constants
   localparam logic [7:0]  CHAR_NEWLINE = 8'h0A;
   localparam logic [7:0]  CHAR_TAB     = 8'h09;
   localparam logic [7:0]  CHAR_SPACE   = 8'h20;
   localparam logic [7:0]  TEXT_ATTR    = 8'h07;
   localparam logic [15:0] BLANK_CELL   = {TEXT_ATTR, CHAR_SPACE};

   // one datapath operation per cycle
   typedef enum logic [3:0] {
      OP_NONE,
      OP_LATCH,
      OP_PUT,
      OP_NEWLINE,
      OP_SCROLL_START,
      OP_SCROLL_RD,
      OP_SCROLL_WR,
      OP_BLANK_WR,
      OP_CLEAR_START,
      OP_CLEAR_WR,
      OP_READ,
      OP_RESPOND
   } op_type;

   typedef struct packed {
      op_type op;
   } dp_cmd_type;

   typedef struct packed {
      logic is_print;
      logic is_clear;
      logic is_read;
      logic is_newline;
      logic is_tab;
      logic scroll_pend;
      logic tab_more;
      logic copy_last;
      logic sweep_last;
      logic rsp_free;
   } dp_status_type;

endpackage

/* design/tcw_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcw_ram: generic single write, single read RAM
// One write port and one read port with a registered read data output.
// ----------------------------------------------------------------------------
module tcw_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 2000
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* design/tcw_datapath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcw_datapath: cursor, sweep counter, cell store and result register
// Executes one operation per cycle as commanded by the controller.
// ----------------------------------------------------------------------------
module tcw_datapath #(
   parameter int COLUMNS  = 80,
   parameter int ROWS     = 25,
   parameter int TAB_STOP = 4
) (
   input  logic                  clock,
   input  logic                  reset,
   input  tcw_pkg::dp_cmd_type   cmd,
   output tcw_pkg::dp_status_type status,
   input  logic [1:0]            req_mode,
   input  logic [7:0]            req_char_code,
   input  logic [10:0]           req_read_index,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [10:0]           rsp_cursor_pos,
   output logic [15:0]           rsp_cell_data,
   output logic                  rsp_scrolled
);
   import tcw_pkg::*;

   localparam int CELLS = COLUMNS * ROWS;
   localparam int AW    = $clog2(CELLS);
   localparam int CW    = $clog2(COLUMNS);
   localparam int RW    = $clog2(ROWS);
   localparam int TW    = $clog2(TAB_STOP + 1);

   localparam logic [AW-1:0]    STEP          = AW'(COLUMNS);
   localparam logic [AW-1:0]    LAST_ROW_BASE = AW'((ROWS - 1) * COLUMNS);
   localparam logic [AW-1:0]    COPY_LAST     = AW'((ROWS - 1) * COLUMNS - 1);
   localparam logic [AW-1:0]    CELL_LAST     = AW'(CELLS - 1);
   localparam logic [CW-1:0]    COL_LAST      = CW'(COLUMNS - 1);
   localparam logic [RW-1:0]    ROW_LAST      = RW'(ROWS - 1);
   localparam logic [TW-1:0]    TAB_N         = TW'(TAB_STOP);
   localparam logic [TW-1:0]    PHASE_LAST    = TW'(TAB_STOP - 1);
   localparam logic [AW+10:0]   CELLS_WIDE    = (AW + 11)'(CELLS);

   // latched request
   logic [1:0]    mode_ff, mode_in;
   logic [7:0]    code_ff, code_in;
   logic [10:0]   ridx_ff, ridx_in;

   // cursor
   logic [CW-1:0] col_ff, col_in;
   logic [RW-1:0] row_ff, row_in;
   logic [AW-1:0] pos_ff, pos_in;
   logic [AW-1:0] base_ff, base_in;
   logic [TW-1:0] phase_ff, phase_in;
   logic [TW-1:0] tab_left_ff, tab_left_in;

   // sweep and flags
   logic [AW-1:0] sweep_ff, sweep_in;
   logic          scroll_pend_ff, scroll_pend_in;
   logic          scrolled_ff, scrolled_in;

   // result register
   logic          rsp_valid_ff, rsp_valid_in;
   logic [10:0]   rsp_pos_ff, rsp_pos_in;
   logic [15:0]   rsp_cell_ff, rsp_cell_in;
   logic          rsp_scrolled_ff, rsp_scrolled_in;

   // store ports
   logic          wr_en, rd_en;
   logic [AW-1:0] wr_addr, rd_addr;
   logic [15:0]   wr_data, rd_data;

   logic [AW+10:0] pos_wide, ridx_wide;
   logic           ridx_ok, is_tab, wrap;
   logic [7:0]     glyph;

   assign pos_wide  = {{11{1'b0}}, pos_ff};
   assign ridx_wide = {{AW{1'b0}}, ridx_ff};
   assign ridx_ok   = ridx_wide < CELLS_WIDE;
   assign is_tab    = code_ff == CHAR_TAB;
   assign glyph     = is_tab ? CHAR_SPACE : code_ff;
   assign wrap      = (cmd.op == OP_NEWLINE) || (cmd.op == OP_PUT && col_ff == COL_LAST);

   tcw_ram #(
      .WIDTH (16),
      .DEPTH (CELLS)
   ) u_cells (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_comb begin
      mode_in         = mode_ff;
      code_in         = code_ff;
      ridx_in         = ridx_ff;
      col_in          = col_ff;
      row_in          = row_ff;
      pos_in          = pos_ff;
      base_in         = base_ff;
      phase_in        = phase_ff;
      tab_left_in     = tab_left_ff;
      sweep_in        = sweep_ff;
      scroll_pend_in  = scroll_pend_ff;
      scrolled_in     = scrolled_ff;
      rsp_valid_in    = rsp_valid_ff && rsp_stall;
      rsp_pos_in      = rsp_pos_ff;
      rsp_cell_in     = rsp_cell_ff;
      rsp_scrolled_in = rsp_scrolled_ff;
      wr_en           = 1'b0;
      wr_addr         = sweep_ff;
      wr_data         = BLANK_CELL;
      rd_en           = 1'b0;
      rd_addr         = sweep_ff + STEP;

      unique case (cmd.op)
         OP_LATCH: begin
            mode_in     = req_mode;
            code_in     = req_char_code;
            ridx_in     = req_read_index;
            scrolled_in = 1'b0;
            tab_left_in = TAB_N - phase_ff;
         end
         OP_PUT, OP_NEWLINE: begin
            if (cmd.op == OP_PUT) begin
               wr_en       = 1'b1;
               wr_addr     = pos_ff;
               wr_data     = {TEXT_ATTR, glyph};
               if (tab_left_ff != '0) begin
                  tab_left_in = tab_left_ff - TW'(1);
               end
            end
            if (wrap) begin
               col_in   = '0;
               phase_in = '0;
               if (row_ff == ROW_LAST) begin
                  pos_in         = LAST_ROW_BASE;
                  base_in        = LAST_ROW_BASE;
                  scroll_pend_in = 1'b1;
                  scrolled_in    = 1'b1;
               end else begin
                  row_in  = row_ff + RW'(1);
                  pos_in  = base_ff + STEP;
                  base_in = base_ff + STEP;
               end
            end else begin
               col_in   = col_ff + CW'(1);
               pos_in   = pos_ff + AW'(1);
               phase_in = (phase_ff == PHASE_LAST) ? '0 : phase_ff + TW'(1);
            end
         end
         OP_SCROLL_START: begin
            sweep_in       = '0;
            scroll_pend_in = 1'b0;
         end
         OP_SCROLL_RD: begin
            rd_en = 1'b1;
         end
         OP_SCROLL_WR: begin
            wr_en    = 1'b1;
            wr_data  = rd_data;
            sweep_in = sweep_ff + AW'(1);
         end
         OP_BLANK_WR, OP_CLEAR_WR: begin
            wr_en    = 1'b1;
            sweep_in = sweep_ff + AW'(1);
         end
         OP_CLEAR_START: begin
            sweep_in = '0;
            col_in   = '0;
            row_in   = '0;
            pos_in   = '0;
            base_in  = '0;
            phase_in = '0;
         end
         OP_READ: begin
            rd_en   = ridx_ok;
            rd_addr = ridx_wide[AW-1:0];
         end
         OP_RESPOND: begin
            rsp_valid_in    = 1'b1;
            rsp_pos_in      = pos_wide[10:0];
            rsp_cell_in     = (mode_ff == MODE_READ && ridx_ok) ? rd_data : 16'h0000;
            rsp_scrolled_in = scrolled_ff;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff         <= '0;
         row_ff         <= '0;
         pos_ff         <= '0;
         base_ff        <= '0;
         phase_ff       <= '0;
         sweep_ff       <= '0;
         scroll_pend_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         col_ff         <= col_in;
         row_ff         <= row_in;
         pos_ff         <= pos_in;
         base_ff        <= base_in;
         phase_ff       <= phase_in;
         sweep_ff       <= sweep_in;
         scroll_pend_ff <= scroll_pend_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
      mode_ff         <= mode_in;
      code_ff         <= code_in;
      ridx_ff         <= ridx_in;
      tab_left_ff     <= tab_left_in;
      scrolled_ff     <= scrolled_in;
      rsp_pos_ff      <= rsp_pos_in;
      rsp_cell_ff     <= rsp_cell_in;
      rsp_scrolled_ff <= rsp_scrolled_in;
   end

   assign status.is_print    = mode_ff == MODE_PRINT;
   assign status.is_clear    = mode_ff == MODE_CLEAR;
   assign status.is_read     = mode_ff == MODE_READ;
   assign status.is_newline  = code_ff == CHAR_NEWLINE;
   assign status.is_tab      = is_tab;
   assign status.scroll_pend = scroll_pend_ff;
   assign status.tab_more    = tab_left_ff != '0;
   assign status.copy_last   = sweep_ff == COPY_LAST;
   assign status.sweep_last  = sweep_ff == CELL_LAST;
   assign status.rsp_free    = !rsp_valid_ff || !rsp_stall;

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_cursor_pos = rsp_pos_ff;
   assign rsp_cell_data  = rsp_cell_ff;
   assign rsp_scrolled   = rsp_scrolled_ff;

`ifndef SYNTHESIS
   // linear cursor always matches row base plus column
   a_pos_matches: assert property (@(posedge clock) disable iff (reset)
      pos_ff == base_ff + AW'(col_ff))
      else $error("cursor position out of step with row base and column");

   // cursor never leaves the store
   a_pos_range: assert property (@(posedge clock) disable iff (reset)
      pos_ff <= CELL_LAST)
      else $error("cursor beyond last cell");

   // a pending scroll leaves the cursor at the start of the bottom row
   a_scroll_home: assert property (@(posedge clock) disable iff (reset)
      scroll_pend_ff |-> (row_ff == ROW_LAST && col_ff == '0))
      else $error("pending scroll with cursor off the bottom row start");

   // a result is only loaded when the register is free
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == OP_RESPOND) |-> (!rsp_valid_ff || !rsp_stall))
      else $error("result register overwritten while stalled");
`endif

endmodule

/* design/tcw_controller.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcw_controller: sequencing state machine of the text console writer
// Steps through print, scroll, clear and read sequences, one datapath
// operation per cycle.
// ----------------------------------------------------------------------------
module tcw_controller (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  tcw_pkg::dp_status_type status,
   output tcw_pkg::dp_cmd_type    cmd
);
   import tcw_pkg::*;

   typedef enum logic [3:0] {
      ST_INIT_CLR,
      ST_IDLE,
      ST_DISPATCH,
      ST_PUT,
      ST_CHECK,
      ST_SCR_RD,
      ST_SCR_WR,
      ST_BLANK,
      ST_CLEAR,
      ST_READ_WAIT,
      ST_DONE
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd.op   = OP_NONE;
      unique case (state_ff)
         ST_INIT_CLR: begin
            cmd.op = OP_CLEAR_WR;
            if (status.sweep_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_valid) begin
               cmd.op   = OP_LATCH;
               state_in = ST_DISPATCH;
            end
         end
         ST_DISPATCH: begin
            priority if (status.is_print && status.is_newline) begin
               cmd.op   = OP_NEWLINE;
               state_in = ST_CHECK;
            end else if (status.is_print) begin
               state_in = ST_PUT;
            end else if (status.is_clear) begin
               cmd.op   = OP_CLEAR_START;
               state_in = ST_CLEAR;
            end else if (status.is_read) begin
               cmd.op   = OP_READ;
               state_in = ST_READ_WAIT;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_PUT: begin
            cmd.op   = OP_PUT;
            state_in = ST_CHECK;
         end
         ST_CHECK: begin
            priority if (status.scroll_pend) begin
               cmd.op   = OP_SCROLL_START;
               state_in = ST_SCR_RD;
            end else if (status.is_tab && status.tab_more) begin
               state_in = ST_PUT;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_SCR_RD: begin
            cmd.op   = OP_SCROLL_RD;
            state_in = ST_SCR_WR;
         end
         ST_SCR_WR: begin
            cmd.op   = OP_SCROLL_WR;
            state_in = status.copy_last ? ST_BLANK : ST_SCR_RD;
         end
         ST_BLANK: begin
            cmd.op = OP_BLANK_WR;
            if (status.sweep_last) state_in = ST_CHECK;
         end
         ST_CLEAR: begin
            cmd.op = OP_CLEAR_WR;
            if (status.sweep_last) state_in = ST_DONE;
         end
         ST_READ_WAIT: begin
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (status.rsp_free) begin
               cmd.op   = OP_RESPOND;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_INIT_CLR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_INIT_CLR;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_stall = state_ff != ST_IDLE;

endmodule

/* design/text_console_writer.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_console_writer: text console engine over a cell store
// Prints bytes with newline, tab and scroll handling, clears the store and
// reads back single cells.
// ----------------------------------------------------------------------------
// usage
//   req channel: one item per request (mode, char_code, read_index), taken
//     when req_valid is high and req_stall low; req_stall is low only while
//     the engine is idle
//   rsp channel: exactly one item per request (cursor_pos, cell_data,
//     scrolled), held stable in an output register while rsp_stall is high;
//     the next request is taken while a result still waits there
//   sequencing: one item at a time, the next request is taken the cycle
//     after the result is loaded
//   scroll: the cell store has a single read and a single write port, so
//     each cell is copied up a row by a read and then a write, then the
//     bottom row is blanked
//   clear: one cell write per cycle across the whole store
//   reset: the store is blanked by a pass over every cell, during which
//     req_stall stays high; the cursor starts at 0
//   a stalled result holds the engine in the next request's final step until taken
// ----------------------------------------------------------------------------
module text_console_writer #(
   parameter int COLUMNS  = 80,
   parameter int ROWS     = 25,
   parameter int TAB_STOP = 4
) (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_mode,
   input  logic [7:0]  req_char_code,
   input  logic [10:0] req_read_index,
   // result channel
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [10:0] rsp_cursor_pos,
   output logic [15:0] rsp_cell_data,
   output logic        rsp_scrolled
);
   import tcw_pkg::*;

   // commands from the sequencer, flags back from the datapath
   dp_cmd_type    cmd;
   dp_status_type status;

   // state machine: print, scroll, clear and read sequences
   tcw_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // cursor, sweep counter, cell store and result register
   tcw_datapath #(
      .COLUMNS  (COLUMNS),
      .ROWS     (ROWS),
      .TAB_STOP (TAB_STOP)
   ) u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .req_mode       (req_mode),
      .req_char_code  (req_char_code),
      .req_read_index (req_read_index),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_cursor_pos (rsp_cursor_pos),
      .rsp_cell_data  (rsp_cell_data),
      .rsp_scrolled   (rsp_scrolled)
   );

endmodule

/* tb/tb_text_console_writer.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_text_console_writer: self-checking testbench of the text console writer
// Drives print, clear, read and unused-mode requests and keeps its own model
// of the 80x25 cell store and cursor. Every result is compared with the
// oldest prediction. Directed tests come first, then random traffic with
// sender gaps and receiver stalls, plus one long receiver hold-off.
// ----------------------------------------------------------------------------
module tb_text_console_writer;
   import tcw_pkg::*;

   localparam int COLUMNS    = 80;
   localparam int ROWS       = 25;
   localparam int TAB_STOP   = 4;
   localparam int CELL_COUNT = COLUMNS * ROWS;

   // mode code the block leaves unused
   localparam logic [1:0] MODE_UNUSED = 2'd3;

   // a scroll walks the whole store, as does the reset pass; the watchdog
   // allows many times as long as either without any handshake
   localparam int WATCHDOG_LIMIT = 40000;
   localparam int HOLD_CYCLES    = 300;
   localparam int DRAIN_CYCLES   = 50;
   localparam int PHASE_ITEMS    = 182;

   typedef struct packed {
      logic [10:0] cursor_pos;
      logic [15:0] cell_data;
      logic        scrolled;
   } console_result_type;

   logic        clock          = 1'b0;
   logic        reset          = 1'b1;
   logic        req_valid      = 1'b0;
   logic        req_stall;
   logic [1:0]  req_mode       = MODE_PRINT;
   logic [7:0]  req_char_code  = 8'h00;
   logic [10:0] req_read_index = 11'd0;
   logic        rsp_valid;
   logic        rsp_stall      = 1'b0;
   logic [10:0] rsp_cursor_pos;
   logic [15:0] rsp_cell_data;
   logic        rsp_scrolled;

   // traffic shaping, in percent per cycle
   int send_idle_pct  = 0;
   int rsp_stall_pct  = 0;
   logic rsp_hold     = 1'b0;

   int mismatch_count = 0;
   int quiet_cycles   = 0;

   console_result_type pending_results[$];
   console_result_type oldest_expected;

   // model of the store and the cursor
   logic [15:0] screen_model [CELL_COUNT];
   int          cur_col;
   int          cur_row;

   text_console_writer #(
      .COLUMNS (COLUMNS),
      .ROWS    (ROWS),
      .TAB_STOP(TAB_STOP)
   ) DUT (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_mode      (req_mode),
      .req_char_code (req_char_code),
      .req_read_index(req_read_index),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_cursor_pos(rsp_cursor_pos),
      .rsp_cell_data (rsp_cell_data),
      .rsp_scrolled  (rsp_scrolled)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ------------------------------------------------------------------
   // console model
   // ------------------------------------------------------------------
   function automatic void blank_screen_model();
      for (int i = 0; i < CELL_COUNT; i++) screen_model[i] = BLANK_CELL;
   endfunction

   // cursor fell off the bottom: move every row up, blank the last one
   function automatic bit scroll_if_past_bottom();
      if (cur_row < ROWS) return 1'b0;
      for (int i = 0; i < (ROWS - 1) * COLUMNS; i++) screen_model[i] = screen_model[i + COLUMNS];
      for (int i = (ROWS - 1) * COLUMNS; i < CELL_COUNT; i++) screen_model[i] = BLANK_CELL;
      cur_row = ROWS - 1;
      return 1'b1;
   endfunction

   // store one glyph at the cursor, advance and wrap at the row end
   function automatic bit place_glyph(logic [7:0] glyph);
      int cell_idx;
      cell_idx = cur_row * COLUMNS + cur_col;
      if (cell_idx < CELL_COUNT) screen_model[cell_idx] = {TEXT_ATTR, glyph};
      cur_col++;
      if (cur_col >= COLUMNS) begin
         cur_col = 0;
         cur_row++;
      end
      return scroll_if_past_bottom();
   endfunction

   function automatic console_result_type apply_console_op(logic [1:0] mode, logic [7:0] glyph,
                                                           logic [10:0] cell_idx);
      console_result_type res;
      int spaces;
      res = '0;
      case (mode)
         MODE_PRINT: begin
            if (glyph == CHAR_NEWLINE) begin
               cur_col = 0;
               cur_row++;
               res.scrolled = scroll_if_past_bottom();
            end else if (glyph == CHAR_TAB) begin
               // pad with spaces to the next tab stop, each may wrap and scroll
               spaces = TAB_STOP - (cur_col % TAB_STOP);
               repeat (spaces) if (place_glyph(CHAR_SPACE)) res.scrolled = 1'b1;
            end else begin
               res.scrolled = place_glyph(glyph);
            end
         end
         MODE_CLEAR: begin
            blank_screen_model();
            cur_col = 0;
            cur_row = 0;
         end
         MODE_READ: begin
            if (cell_idx < CELL_COUNT) res.cell_data = screen_model[cell_idx];
         end
         default: ;
      endcase
      res.cursor_pos = 11'(cur_row * COLUMNS + cur_col);
      return res;
   endfunction

   // ------------------------------------------------------------------
   // request side: offer one item, hold it until taken, then predict
   // ------------------------------------------------------------------
   task automatic send_item(logic [1:0] mode, logic [7:0] glyph, logic [10:0] cell_idx);
      // random gap before the item; valid drops only when a gap is taken
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_valid      <= 1'b1;
      req_mode       <= mode;
      req_char_code  <= glyph;
      req_read_index <= cell_idx;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      pending_results.push_back(apply_console_op(mode, glyph, cell_idx));
   endtask

   // mostly text with line breaks and tabs, reads near the cursor and at random,
   // a few unused-mode items and rare clears
   task automatic send_random_op();
      int pick;
      int near_idx;
      logic [7:0] glyph;
      logic [10:0] cell_idx;
      pick     = $urandom_range(999);
      glyph    = 8'($urandom_range(255));
      cell_idx = 11'($urandom_range(2047));
      if (pick < 560) begin
         send_item(MODE_PRINT, glyph, cell_idx);
      end else if (pick < 700) begin
         send_item(MODE_PRINT, CHAR_NEWLINE, cell_idx);
      end else if (pick < 780) begin
         send_item(MODE_PRINT, CHAR_TAB, cell_idx);
      end else if (pick < 900) begin
         // read back something recently written
         near_idx = cur_row * COLUMNS + cur_col - int'($urandom_range(100));
         if (near_idx < 0) near_idx = 0;
         send_item(MODE_READ, glyph, 11'(near_idx));
      end else if (pick < 960) begin
         send_item(MODE_READ, glyph, cell_idx);
      end else if (pick < 995) begin
         send_item(MODE_UNUSED, glyph, cell_idx);
      end else begin
         send_item(MODE_CLEAR, glyph, cell_idx);
      end
   endtask

   // ------------------------------------------------------------------
   // result side: random stall, check every item taken
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      rsp_stall <= rsp_hold || ($urandom_range(99) < rsp_stall_pct);
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_results.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("%0t: result with nothing pending: pos=%0d cell=%h scrolled=%b",
                        $realtime, rsp_cursor_pos, rsp_cell_data, rsp_scrolled);
         end else begin
            oldest_expected = pending_results.pop_front();
            if (rsp_cursor_pos !== oldest_expected.cursor_pos ||
                rsp_cell_data  !== oldest_expected.cell_data  ||
                rsp_scrolled   !== oldest_expected.scrolled) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display({"%0t: mismatch: pos exp %0d act %0d, cell exp %h act %h,",
                            " scrolled exp %b act %b"},
                           $realtime, oldest_expected.cursor_pos, rsp_cursor_pos,
                           oldest_expected.cell_data, rsp_cell_data,
                           oldest_expected.scrolled, rsp_scrolled);
            end
         end
      end
   end

   // watchdog: cycles with no handshake on either channel
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("end of test: mismatches");
         $finish;
      end
   end

   // ------------------------------------------------------------------
   // tests
   // ------------------------------------------------------------------

   // byte extremes, both halves of the code range
   task automatic test_print_extremes();
      send_item(MODE_PRINT, 8'h00, 11'd0);
      send_item(MODE_PRINT, 8'hFF, 11'h7FF);
      send_item(MODE_PRINT, 8'h7F, 11'd0);
      send_item(MODE_PRINT, 8'h80, 11'h7FF);
      send_item(MODE_PRINT, 8'h41, 11'd0);
   endtask

   // newline, then tabs from column 0 and from mid stop
   task automatic test_control_bytes();
      send_item(MODE_PRINT, CHAR_NEWLINE, 11'd0);
      send_item(MODE_PRINT, CHAR_TAB, 11'd0);
      send_item(MODE_PRINT, 8'h42, 11'd0);
      send_item(MODE_PRINT, CHAR_TAB, 11'd0);
   endtask

   // reads in range, at the last cell and past the end of the store
   task automatic test_cell_reads();
      send_item(MODE_READ, 8'h00, 11'd0);
      send_item(MODE_READ, 8'hFF, 11'd1);
      send_item(MODE_READ, 8'h00, 11'(COLUMNS));
      send_item(MODE_READ, 8'h00, 11'(CELL_COUNT - 1));
      send_item(MODE_READ, 8'h00, 11'(CELL_COUNT));
      send_item(MODE_READ, 8'hFF, 11'h7FF);
   endtask

   // unused mode changes nothing
   task automatic test_unused_mode();
      send_item(MODE_UNUSED, 8'hFF, 11'h7FF);
      send_item(MODE_UNUSED, CHAR_NEWLINE, 11'd0);
      send_item(MODE_READ, 8'h00, 11'd2);
   endtask

   // clear blanks the store and homes the cursor
   task automatic test_clear_screen();
      send_item(MODE_CLEAR, 8'hFF, 11'h7FF);
      send_item(MODE_READ, 8'h00, 11'd0);
      send_item(MODE_READ, 8'h00, 11'(COLUMNS + 4));
   endtask

   // walk to the bottom row, scroll by newline, then by a tab at the row end
   task automatic test_scroll_and_tab();
      send_item(MODE_CLEAR, 8'h00, 11'd0);
      repeat (ROWS - 1) send_item(MODE_PRINT, CHAR_NEWLINE, 11'd0);
      send_item(MODE_PRINT, 8'h5A, 11'd0);
      send_item(MODE_PRINT, CHAR_NEWLINE, 11'd0);
      send_item(MODE_READ, 8'h00, 11'((ROWS - 2) * COLUMNS));
      repeat (COLUMNS / TAB_STOP - 1) send_item(MODE_PRINT, CHAR_TAB, 11'd0);
      send_item(MODE_PRINT, 8'h51, 11'd0);
      // tab from the middle of the last stop wraps and scrolls
      send_item(MODE_PRINT, CHAR_TAB, 11'd0);
      send_item(MODE_READ, 8'h00, 11'((ROWS - 2) * COLUMNS + COLUMNS - TAB_STOP));
      send_item(MODE_READ, 8'h00, 11'((ROWS - 1) * COLUMNS));
      // ordinary byte in the last cell also scrolls
      repeat (COLUMNS - 1) send_item(MODE_PRINT, 8'h2E, 11'd0);
      send_item(MODE_PRINT, 8'h21, 11'd0);
   endtask

   // receiver holds off for a long stretch while the sender keeps offering
   task automatic test_result_backpressure();
      send_idle_pct = 0;
      rsp_stall_pct <= 0;
      rsp_hold      <= 1'b1;
      fork
         begin
            repeat (HOLD_CYCLES) @(posedge clock);
            rsp_hold <= 1'b0;
         end
         repeat (20) send_item(MODE_PRINT, 8'($urandom_range(8'h21, 8'h7E)), 11'd0);
      join
   endtask

   task automatic run_random_phase(int sender_pct, int receiver_pct);
      send_idle_pct = sender_pct;
      rsp_stall_pct <= receiver_pct;
      repeat (PHASE_ITEMS) send_random_op();
   endtask

   task automatic test_random_streaming();
      run_random_phase(0, 0);
   endtask

   task automatic test_random_sender_gaps();
      run_random_phase(82, 0);
   endtask

   task automatic test_random_receiver_stalls();
      run_random_phase(0, 82);
   endtask

   task automatic test_random_both_idle();
      run_random_phase(20, 20);
   endtask

   // ------------------------------------------------------------------
   // sequence
   // ------------------------------------------------------------------
   initial begin
      blank_screen_model();
      cur_col = 0;
      cur_row = 0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // the block blanks its store after reset; send_item waits it out
      test_print_extremes();
      test_control_bytes();
      test_cell_reads();
      test_unused_mode();
      test_clear_screen();
      test_scroll_and_tab();
      test_result_backpressure();
      test_random_streaming();
      test_random_sender_gaps();
      test_random_receiver_stalls();
      test_random_both_idle();

      req_valid <= 1'b0;
      rsp_stall_pct <= 0;
      while (pending_results.size() != 0) @(posedge clock);
      // catch any stray result after the last expected one
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

endmodule

/* sim.f */
design/tcw_pkg.sv
design/tcw_ram.sv
design/tcw_datapath.sv
design/tcw_controller.sv
design/text_console_writer.sv
tb/tb_text_console_writer.sv
